@@ design/dhnc_pkg.sv @@
package dhnc_pkg;

    localparam int LEN_W = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_INCREMENTED = 3'd1,
        ST_FOUND       = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_FULL        = 3'd4,
        ST_TOO_LONG    = 3'd5
    } status_t;

    typedef struct packed {
        logic    take_byte;
        logic    prb_rd;
        logic    prb_next;
        logic    collide;
        logic    cmp_start;
        logic    char_rd;
        logic    j_next;
        logic    char_wr;
        logic    cnt_wr;
        logic    claim;
        logic    set_res;
        status_t res_code;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic overflow_now;
        logic is_lookup;
        logic slot_used;
        logic len_eq;
        logic char_eq;
        logic j_last;
        logic i_last;
        logic out_free;
    } stat_t;

endpackage

@@ design/dhnc_if.sv @@
interface dhnc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_byte;
    logic       last;

    modport source (output valid, output command, output char_byte, output last, input ready);
    modport sink (input valid, input command, input char_byte, input last, output ready);
endinterface

interface dhnc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] count;
    logic [6:0]  slot;
    logic [31:0] collision_total;
    logic [6:0]  unique_total;

    modport source (output valid, output status, output count, output slot,
                    output collision_total, output unique_total, input ready);
    modport sink (input valid, input status, input count, input slot,
                  input collision_total, input unique_total, output ready);
endinterface

@@ design/dhnc_ctrl.sv @@
module dhnc_ctrl
    import dhnc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_last,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PRB_RD = 8'b0000_0010,
        S_PRB_CK = 8'b0000_0100,
        S_CMP_RD = 8'b0000_1000,
        S_CMP_CK = 8'b0001_0000,
        S_CPY_RD = 8'b0010_0000,
        S_CPY_WR = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.res_code = ST_NOT_FOUND;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_byte = 1'b1;
                    if (in_last)
                    begin
                        if (st.overflow_now)
                        begin
                            cmd.set_res = 1'b1;
                            cmd.res_code = ST_TOO_LONG;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_PRB_RD;
                        end
                    end
                end
            end
            S_PRB_RD:
            begin
                cmd.prb_rd = 1'b1;
                state_next = S_PRB_CK;
            end
            S_PRB_CK, S_CMP_CK:
            begin
                if (state_reg == S_PRB_CK && !st.slot_used)
                begin
                    if (st.is_lookup)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_code = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.cmp_start = 1'b1;
                        state_next = S_CPY_RD;
                    end
                end
                else if (state_reg == S_PRB_CK && st.len_eq)
                begin
                    cmd.cmp_start = 1'b1;
                    state_next = S_CMP_RD;
                end
                else if (state_reg == S_CMP_CK && st.char_eq && !st.j_last)
                begin
                    cmd.j_next = 1'b1;
                    state_next = S_CMP_RD;
                end
                else if (state_reg == S_CMP_CK && st.char_eq)
                begin
                    cmd.set_res = 1'b1;
                    cmd.cnt_wr = !st.is_lookup;
                    cmd.res_code = st.is_lookup ? ST_FOUND : ST_INCREMENTED;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.collide = !st.is_lookup;
                    if (st.i_last)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_code = st.is_lookup ? ST_NOT_FOUND : ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.prb_next = 1'b1;
                        state_next = S_PRB_RD;
                    end
                end
            end
            S_CMP_RD:
            begin
                cmd.char_rd = 1'b1;
                state_next = S_CMP_CK;
            end
            S_CPY_RD:
            begin
                cmd.char_rd = 1'b1;
                state_next = S_CPY_WR;
            end
            S_CPY_WR:
            begin
                cmd.char_wr = 1'b1;
                if (st.j_last)
                begin
                    cmd.claim = 1'b1;
                    cmd.set_res = 1'b1;
                    cmd.res_code = ST_INSERTED;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.j_next = 1'b1;
                    state_next = S_CPY_RD;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/dhnc_dp.sv @@
module dhnc_dp
    import dhnc_pkg::*;
#(
    parameter int SLOTS = 71,
    parameter int MAX_CHARS = 29
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        command,
    input  logic [7:0]  char_byte,
    input  logic        last,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  status,
    output logic [15:0] count,
    output logic [6:0]  slot,
    output logic [31:0] collision_total,
    output logic [6:0]  unique_total
);

    localparam int SW = $clog2(SLOTS);
    localparam int BW = $clog2(MAX_CHARS);
    localparam int UW = $clog2(SLOTS + 1);
    localparam int CAW = $clog2(SLOTS * MAX_CHARS);

    typedef logic [SW-1:0] tab_t [256];

    function automatic tab_t mod_tab(int m);
        tab_t t;
        int   r;
        for (int v = 0; v < 256; v++)
        begin
            r = v;
            for (int n = 0; n < 256; n++)
            begin
                if (r >= m)
                begin
                    r = r - m;
                end
            end
            t[v] = SW'(r);
        end
        return t;
    endfunction

    localparam tab_t MOD1 = mod_tab(SLOTS);
    localparam tab_t MOD2 = mod_tab(SLOTS - 1);

    logic [7:0]     buf_mem [MAX_CHARS];
    logic [7:0]     chr_mem [SLOTS * MAX_CHARS];
    logic [LEN_W-1:0] len_mem [SLOTS];
    logic [15:0]    cnt_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;

    logic [LEN_W-1:0] name_len_reg;
    logic           ovf_reg;
    logic [SW-1:0]  h1_reg;
    logic [SW-1:0]  h2_reg;
    logic [SW-1:0]  h1_next;
    logic [SW-1:0]  h2_next;
    logic [SW:0]    h1_sum;
    logic [SW:0]    h2_sum;
    logic [SW:0]    k_sum;
    logic [SW-1:0]  k_reg;
    logic [SW-1:0]  i_reg;
    logic [BW-1:0]  j_reg;
    logic           lookup_reg;
    logic [31:0]    coll_reg;
    logic [UW-1:0]  uniq_reg;
    logic [7:0]     buf_rd_reg;
    logic [7:0]     chr_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;
    logic [15:0]    cnt_rd_reg;
    logic [15:0]    cnt_inc;
    logic [CAW-1:0] chr_addr;
    logic           len_ok;
    status_t        res_status_reg;
    logic [15:0]    res_count_reg;
    logic [SW-1:0]  res_slot_reg;
    logic           out_valid_reg;
    logic [2:0]     status_reg;
    logic [15:0]    count_reg;
    logic [6:0]     slot_reg;
    logic [31:0]    coll_out_reg;
    logic [6:0]     uniq_out_reg;

    assign len_ok = name_len_reg < LEN_W'(MAX_CHARS);
    assign h1_sum = {1'b0, h1_reg} + {1'b0, MOD1[char_byte]};
    assign h1_next = (h1_sum >= (SW+1)'(SLOTS)) ? SW'(h1_sum - (SW+1)'(SLOTS)) : SW'(h1_sum);
    assign h2_sum = {1'b0, h2_reg} + {1'b0, MOD2[char_byte]};
    assign h2_next = (h2_sum >= (SW+1)'(SLOTS - 1))
                   ? SW'(h2_sum - (SW+1)'(SLOTS - 1) + (SW+1)'(1))
                   : SW'(h2_sum + (SW+1)'(1));
    assign k_sum = {1'b0, k_reg} + {1'b0, h2_reg};
    assign chr_addr = CAW'(k_reg) * CAW'(MAX_CHARS) + CAW'(j_reg);
    assign cnt_inc = (cnt_rd_reg == 16'hFFFF) ? cnt_rd_reg : cnt_rd_reg + 16'd1;

    assign st.overflow_now = ovf_reg || !len_ok;
    assign st.is_lookup = (lookup_reg == CMD_LOOKUP);
    assign st.slot_used = valid_reg[k_reg];
    assign st.len_eq = (len_rd_reg == name_len_reg);
    assign st.char_eq = (chr_rd_reg == buf_rd_reg);
    assign st.j_last = ((LEN_W'(j_reg) + LEN_W'(1)) == name_len_reg);
    assign st.i_last = (i_reg == SW'(SLOTS - 1));
    assign st.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && len_ok)
        begin
            buf_mem[name_len_reg[BW-1:0]] <= char_byte;
        end
        if (cmd.char_rd)
        begin
            buf_rd_reg <= buf_mem[j_reg];
            chr_rd_reg <= chr_mem[chr_addr];
        end
        if (cmd.char_wr)
        begin
            chr_mem[chr_addr] <= buf_rd_reg;
        end
        if (cmd.prb_rd)
        begin
            len_rd_reg <= len_mem[k_reg];
            cnt_rd_reg <= cnt_mem[k_reg];
        end
        if (cmd.claim)
        begin
            len_mem[k_reg] <= name_len_reg;
        end
        if (cmd.claim || cmd.cnt_wr)
        begin
            cnt_mem[k_reg] <= cmd.claim ? 16'd1 : cnt_inc;
        end
        if (cmd.take_byte && last)
        begin
            k_reg <= h1_next;
            i_reg <= '0;
            lookup_reg <= command;
        end
        else if (cmd.prb_next)
        begin
            k_reg <= (k_sum >= (SW+1)'(SLOTS)) ? SW'(k_sum - (SW+1)'(SLOTS)) : SW'(k_sum);
            i_reg <= i_reg + SW'(1);
        end
        if (cmd.cmp_start)
        begin
            j_reg <= '0;
        end
        else if (cmd.j_next)
        begin
            j_reg <= j_reg + BW'(1);
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_code;
            case (cmd.res_code)
                ST_INSERTED:
                begin
                    res_count_reg <= 16'd1;
                    res_slot_reg <= k_reg;
                end
                ST_INCREMENTED:
                begin
                    res_count_reg <= cnt_inc;
                    res_slot_reg <= k_reg;
                end
                ST_FOUND:
                begin
                    res_count_reg <= cnt_rd_reg;
                    res_slot_reg <= k_reg;
                end
                default:
                begin
                    res_count_reg <= '0;
                    res_slot_reg <= '0;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            status_reg <= res_status_reg;
            count_reg <= res_count_reg;
            slot_reg <= 7'(res_slot_reg);
            coll_out_reg <= coll_reg;
            uniq_out_reg <= 7'(uniq_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            name_len_reg <= '0;
            ovf_reg <= 1'b0;
            h1_reg <= '0;
            h2_reg <= '0;
            coll_reg <= '0;
            uniq_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                if (len_ok)
                begin
                    name_len_reg <= name_len_reg + LEN_W'(1);
                    h1_reg <= h1_next;
                    h2_reg <= h2_next;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            else if (cmd.load_out)
            begin
                name_len_reg <= '0;
                ovf_reg <= 1'b0;
                h1_reg <= '0;
                h2_reg <= '0;
            end
            if (cmd.collide && coll_reg != 32'hFFFF_FFFF)
            begin
                coll_reg <= coll_reg + 32'd1;
            end
            if (cmd.claim)
            begin
                valid_reg[k_reg] <= 1'b1;
                uniq_reg <= uniq_reg + UW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign count = count_reg;
    assign slot = slot_reg;
    assign collision_total = coll_out_reg;
    assign unique_total = uniq_out_reg;

endmodule

@@ design/double_hash_name_counter.sv @@
// Each byte word that does not end a name is accepted in the idle state.
// A final byte word is accepted, then each probed slot is read and checked, each stored character
// compared is read and checked, each character copied on a new insert is read and written, and
// the result is loaded into the output register. That load waits while the output register still
// holds a result word not yet taken.
// Reset clears the occupancy bits, collision and unique counters, hashes and output valid at once; no clearing pass.
module double_hash_name_counter
    import dhnc_pkg::*;
#(
    parameter int SLOTS = 71,
    parameter int MAX_CHARS = 29
)
(
    input logic        clk,
    input logic        rst_n,
    dhnc_in_if.sink    byte_ch,
    dhnc_out_if.source result_ch
);

    cmd_t  cmd;
    stat_t st;

    dhnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_last  (byte_ch.last),
        .in_ready (byte_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    dhnc_dp #(
        .SLOTS     (SLOTS),
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (byte_ch.command),
        .char_byte       (byte_ch.char_byte),
        .last            (byte_ch.last),
        .cmd             (cmd),
        .st              (st),
        .out_ready       (result_ch.ready),
        .out_valid       (result_ch.valid),
        .status          (result_ch.status),
        .count           (result_ch.count),
        .slot            (result_ch.slot),
        .collision_total (result_ch.collision_total),
        .unique_total    (result_ch.unique_total)
    );

endmodule

@@ design/dhnc_chk.sv @@
module dhnc_chk
    import dhnc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] count
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(count))
        else $error("result word changed while stalled");

    a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_INSERTED |-> count == 16'd1)
        else $error("new name without a count of one");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND || status == ST_FULL || status == ST_TOO_LONG)
        |-> count == 16'd0)
        else $error("miss with a nonzero count");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INCREMENTED || status == ST_FOUND) |-> count != 16'd0)
        else $error("hit with a zero count");

endmodule

bind double_hash_name_counter dhnc_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .status    (result_ch.status),
    .count     (result_ch.count)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import dhnc_pkg::*;

    localparam int SLOTS = 71;
    localparam int MAX_CHARS = 29;

    typedef struct {
        status_t     status;
        logic [15:0] count;
        logic [6:0]  slot;
        logic [31:0] collisions;
        logic [6:0]  uniques;
    } name_result_t;

    typedef struct {
        logic         command;
        int           length;
        logic [7:0]   first_byte;
        bit           typed;
        name_result_t result;
    } name_row_t;

    logic clk;
    logic rst_n;
    bit   failed;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   sent_words;

    dhnc_in_if  byte_ch ();
    dhnc_out_if result_ch ();

    double_hash_name_counter #(.SLOTS(SLOTS), .MAX_CHARS(MAX_CHARS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch.sink),
        .result_ch (result_ch.source)
    );

    logic [4:0]   table_len [SLOTS];
    logic [7:0]   table_chars [SLOTS][MAX_CHARS];
    logic [15:0]  table_count [SLOTS];
    logic [7:0]   pending_name [MAX_CHARS];
    int           pending_len;
    int           hash_primary;
    int           hash_step;
    bit           pending_overflow;
    logic [31:0]  collision_sum;
    int           unique_sum;
    name_result_t pending_results [$];

    logic [7:0]   pool_chars [90][MAX_CHARS];
    int           pool_len [90];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic bit stored_name_matches(int s);
        if (table_len[s] != pending_len)
            return 1'b0;
        for (int j = 0; j < pending_len; j++)
            if (table_chars[s][j] != pending_name[j])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic count_name_byte(input logic command, input logic [7:0] b, input logic last,
                                   output bit has_result, output name_result_t r);
        int  k;
        bit  done;
        has_result = 1'b0;
        done = 1'b0;
        r.status = ST_NOT_FOUND;
        r.count = '0;
        r.slot = '0;
        if (pending_len < MAX_CHARS)
        begin
            pending_name[pending_len] = b;
            pending_len++;
            hash_primary = (hash_primary + b) % SLOTS;
            hash_step = 1 + (hash_step + b) % (SLOTS - 1);
        end
        else
            pending_overflow = 1'b1;
        if (!last)
            return;
        has_result = 1'b1;
        if (pending_overflow)
            r.status = ST_TOO_LONG;
        else
        begin
            for (int i = 0; i < SLOTS && !done; i++)
            begin
                k = (hash_primary + i * hash_step) % SLOTS;
                if (table_len[k] == 0)
                begin
                    if (command == CMD_INSERT)
                    begin
                        for (int j = 0; j < pending_len; j++)
                            table_chars[k][j] = pending_name[j];
                        table_len[k] = 5'(pending_len);
                        table_count[k] = 16'd1;
                        unique_sum++;
                        r.status = ST_INSERTED;
                        r.count = 16'd1;
                        r.slot = 7'(k);
                    end
                    done = 1'b1;
                end
                else if (stored_name_matches(k))
                begin
                    if (command == CMD_INSERT)
                    begin
                        if (table_count[k] != 16'hFFFF)
                            table_count[k]++;
                        r.status = ST_INCREMENTED;
                    end
                    else
                        r.status = ST_FOUND;
                    r.count = table_count[k];
                    r.slot = 7'(k);
                    done = 1'b1;
                end
                else if (command == CMD_INSERT && collision_sum != 32'hFFFF_FFFF)
                    collision_sum++;
            end
            if (!done)
                r.status = (command == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end
        r.collisions = collision_sum;
        r.uniques = 7'(unique_sum);
        pending_len = 0;
        hash_primary = 0;
        hash_step = 0;
        pending_overflow = 1'b0;
    endtask

    task automatic send_word(input logic command, input logic [7:0] b, input logic last,
                             input bit typed, input name_result_t typed_result);
        bit           has_result;
        name_result_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid = 1'b1;
        byte_ch.command = command;
        byte_ch.char_byte = b;
        byte_ch.last = last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        count_name_byte(command, b, last, has_result, r);
        if (has_result)
            pending_results.push_back(typed ? typed_result : r);
        sent_words++;
        @(negedge clk);
    endtask

    task automatic send_pool_name(input int p, input logic command);
        name_result_t none;
        for (int j = 0; j < pool_len[p]; j++)
            send_word(command, pool_chars[p][j], j == pool_len[p] - 1, 1'b0, none);
    endtask

    task automatic send_random_name(input int len, input logic command);
        name_result_t none;
        for (int j = 0; j < len; j++)
            send_word(command, 8'($urandom_range(255, 1)), j == len - 1, 1'b0, none);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            result_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result word");
                    failed = 1'b1;
                end
                else
                begin
                    name_result_t e;
                    e = pending_results.pop_front();
                    if (result_ch.status != e.status)
                    begin
                        $error("status expected %0d got %0d", e.status, result_ch.status);
                        failed = 1'b1;
                    end
                    if (result_ch.count != e.count)
                    begin
                        $error("count expected %0d got %0d", e.count, result_ch.count);
                        failed = 1'b1;
                    end
                    if (result_ch.slot != e.slot)
                    begin
                        $error("slot expected %0d got %0d", e.slot, result_ch.slot);
                        failed = 1'b1;
                    end
                    if (result_ch.collision_total != e.collisions)
                    begin
                        $error("collision_total expected %0d got %0d", e.collisions,
                               result_ch.collision_total);
                        failed = 1'b1;
                    end
                    if (result_ch.unique_total != e.uniques)
                    begin
                        $error("unique_total expected %0d got %0d", e.uniques,
                               result_ch.unique_total);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        name_row_t    directed [10];
        name_result_t none;
        int           roll;
        int           waited;

        failed = 1'b0;
        sent_words = 0;
        sender_idle_pct = 38;
        receiver_stall_pct = 74;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.command = CMD_INSERT;
        byte_ch.char_byte = 8'd0;
        byte_ch.last = 1'b0;
        result_ch.ready = 1'b0;
        for (int s = 0; s < SLOTS; s++)
            table_len[s] = '0;
        pending_len = 0;
        hash_primary = 0;
        hash_step = 0;
        pending_overflow = 1'b0;
        collision_sum = '0;
        unique_sum = 0;
        none = '{ST_NOT_FOUND, 16'd0, 7'd0, 32'd0, 7'd0};

        for (int p = 0; p < 90; p++)
        begin
            pool_len[p] = ($urandom_range(9) == 0) ? MAX_CHARS : $urandom_range(8, 1);
            for (int j = 0; j < MAX_CHARS; j++)
                pool_chars[p][j] = 8'($urandom_range(255, 1));
        end

        directed[0] = '{CMD_INSERT, 31, 8'h01, 1'b1, '{ST_TOO_LONG, 16'd0, 7'd0, 32'd0, 7'd0}};
        directed[1] = '{CMD_LOOKUP, 1, 8'hFF, 1'b1, '{ST_NOT_FOUND, 16'd0, 7'd0, 32'd0, 7'd0}};
        directed[2] = '{CMD_INSERT, 1, 8'hFF, 1'b0, none};
        directed[3] = '{CMD_INSERT, 1, 8'hFF, 1'b0, none};
        directed[4] = '{CMD_LOOKUP, 1, 8'hFF, 1'b0, none};
        directed[5] = '{CMD_INSERT, 29, 8'h80, 1'b0, none};
        directed[6] = '{CMD_LOOKUP, 29, 8'h80, 1'b0, none};
        directed[7] = '{CMD_INSERT, 1, 8'h01, 1'b0, none};
        directed[8] = '{CMD_INSERT, 2, 8'h47, 1'b0, none};
        directed[9] = '{CMD_INSERT, 30, 8'h10, 1'b0, none};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[r])
            for (int j = 0; j < directed[r].length; j++)
                send_word(directed[r].command, 8'(directed[r].first_byte + j),
                          j == directed[r].length - 1, directed[r].typed, directed[r].result);

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 74 : 0;
            receiver_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 38 : 0;
            while (sent_words < 550 * (phase + 1))
            begin
                roll = $urandom_range(99);
                if (roll < 85)
                    send_pool_name($urandom_range(89),
                                   ($urandom_range(99) < 70) ? CMD_INSERT : CMD_LOOKUP);
                else if (roll < 92)
                    send_random_name($urandom_range(34, MAX_CHARS + 1), 1'($urandom_range(1)));
                else
                    send_random_name($urandom_range(6, 1), 1'($urandom_range(1)));
            end
        end
        byte_ch.valid = 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 1_000_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
